// ===== rtl/core/rbn_pkg.sv =====
package rbn_pkg;

   localparam int RBN_QUEUE_DEPTH = 2;
   localparam int NUM_PLACES = 4;

   typedef logic [3:0] digit_type;
   typedef logic [1:0] place_type;
   typedef logic [2:0] step_type;
   typedef logic [7:0] symbol_type;

   localparam place_type PLACE_THOUSANDS = 2'd0;
   localparam place_type PLACE_HUNDREDS  = 2'd1;
   localparam place_type PLACE_TENS      = 2'd2;
   localparam place_type PLACE_ONES      = 2'd3;

   localparam symbol_type SYM_I = 8'h49;
   localparam symbol_type SYM_V = 8'h56;
   localparam symbol_type SYM_X = 8'h58;
   localparam symbol_type SYM_L = 8'h4C;
   localparam symbol_type SYM_C = 8'h43;
   localparam symbol_type SYM_D = 8'h44;
   localparam symbol_type SYM_M = 8'h4D;

   typedef struct packed {
      digit_type [NUM_PLACES-1:0] digits;
      place_type                  last_place;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   function automatic logic [13:0] place_scale(place_type p);
      logic [13:0] s;
      case (p)
         PLACE_THOUSANDS: s = 14'd1000;
         PLACE_HUNDREDS:  s = 14'd100;
         PLACE_TENS:      s = 14'd10;
         default:         s = 14'd1;
      endcase
      return s;
   endfunction

   // Number of characters that one digit produces at its place.
   function automatic step_type digit_len(digit_type d, place_type p);
      step_type n;
      if (p == PLACE_THOUSANDS) begin
         n = d[2:0];
      end else if (d == 4'd9 || d == 4'd4) begin
         n = 3'd2;
      end else if (d >= 4'd5) begin
         n = 3'(d - 4'd4);
      end else begin
         n = d[2:0];
      end
      return n;
   endfunction

   function automatic symbol_type digit_symbol(digit_type d, place_type p, step_type step);
      symbol_type one_s;
      symbol_type five_s;
      symbol_type ten_s;
      symbol_type s;
      case (p)
         PLACE_THOUSANDS: begin
            one_s  = SYM_M;
            five_s = SYM_M;
            ten_s  = SYM_M;
         end
         PLACE_HUNDREDS: begin
            one_s  = SYM_C;
            five_s = SYM_D;
            ten_s  = SYM_M;
         end
         PLACE_TENS: begin
            one_s  = SYM_X;
            five_s = SYM_L;
            ten_s  = SYM_C;
         end
         default: begin
            one_s  = SYM_I;
            five_s = SYM_V;
            ten_s  = SYM_X;
         end
      endcase
      if (p == PLACE_THOUSANDS) begin
         s = one_s;
      end else if (d == 4'd9) begin
         s = (step == 3'd0) ? one_s : ten_s;
      end else if (d == 4'd4) begin
         s = (step == 3'd0) ? one_s : five_s;
      end else if (d >= 4'd5) begin
         s = (step == 3'd0) ? five_s : one_s;
      end else begin
         s = one_s;
      end
      return s;
   endfunction

endpackage

// ===== rtl/core/rbn_front.sv =====
module rbn_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [11:0]        req_value,
   input  logic               queue_full,
   output logic               push,
   output rbn_pkg::entry_type push_entry
);
   import rbn_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [11:0]                rem_ff, rem_in;
   place_type                  place_ff, place_in;
   digit_type [NUM_PLACES-1:0] digits_ff, digits_in;

   logic [13:0] scale;
   logic [13:0] product;
   digit_type   digit;
   place_type   last_place;
   logic        any_nonzero;

   always_comb begin
      scale   = place_scale(place_ff);
      digit   = '0;
      product = '0;
      for (int k = 1; k <= 9; k++) begin
         if ({2'b00, rem_ff} >= 14'(k) * scale) begin
            digit   = 4'(k);
            product = 14'(k) * scale;
         end
      end
   end

   always_comb begin
      last_place  = PLACE_THOUSANDS;
      any_nonzero = 1'b0;
      for (int i = 0; i < NUM_PLACES; i++) begin
         if (digits_ff[i] != '0) begin
            last_place  = 2'(i);
            any_nonzero = 1'b1;
         end
      end
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign push                  = (state_ff == ST_PUSH) && any_nonzero && !queue_full;
   assign push_entry.digits     = digits_ff;
   assign push_entry.last_place = last_place;

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      place_in  = place_ff;
      digits_in = digits_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rem_in   = req_value;
               place_in = PLACE_THOUSANDS;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            digits_in[place_ff] = digit;
            rem_in              = rem_ff - product[11:0];
            if (place_ff == PLACE_ONES) begin
               state_in = ST_PUSH;
            end else begin
               place_in = place_ff + 2'd1;
            end
         end
         ST_PUSH: begin
            if (!any_nonzero || !queue_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         place_ff <= PLACE_THOUSANDS;
      end else begin
         state_ff <= state_in;
         place_ff <= place_in;
      end
      rem_ff    <= rem_in;
      digits_ff <= digits_in;
   end

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_CONV))
      else $error("accepted item did not start conversion");

endmodule

// ===== rtl/core/rbn_queue.sv =====
module rbn_queue #(
   parameter int Depth = rbn_pkg::RBN_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rbn_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output rbn_pkg::head_type  head
);
   import rbn_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   entry_type         mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   count_ff;

   assign full       = (count_ff == CntW'(Depth));
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue read while empty");

endmodule

// ===== rtl/core/rbn_back.sv =====
module rbn_back (
   input  logic              clock,
   input  logic              reset,
   input  rbn_pkg::head_type head,
   output logic              pop,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_symbol,
   output logic              rsp_last
);
   import rbn_pkg::*;

   logic       active_ff, active_in;
   entry_type  entry_ff, entry_in;
   place_type  place_ff, place_in;
   step_type   step_ff, step_in;
   logic       strobe_ff;
   symbol_type symbol_ff;
   logic       last_ff;

   digit_type  digit;
   step_type   len;
   logic       has_char;
   logic       char_end;
   logic       item_end;

   assign digit    = entry_ff.digits[place_ff];
   assign len      = digit_len(digit, place_ff);
   assign has_char = active_ff && (step_ff < len);
   assign char_end = has_char && (step_ff == len - 3'd1);
   assign item_end = char_end && (place_ff == entry_ff.last_place);
   assign pop      = head.valid && (!active_ff || item_end);

   always_comb begin
      active_in = active_ff;
      entry_in  = entry_ff;
      place_in  = place_ff;
      step_in   = step_ff;
      if (active_ff) begin
         if (has_char && !char_end) begin
            step_in = step_ff + 3'd1;
         end else begin
            place_in = place_ff + 2'd1;
            step_in  = '0;
         end
         if (item_end) begin
            active_in = 1'b0;
         end
      end
      if (pop) begin
         active_in = 1'b1;
         entry_in  = head.entry;
         place_in  = PLACE_THOUSANDS;
         step_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
         place_ff  <= PLACE_THOUSANDS;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= has_char;
         place_ff  <= place_in;
         step_ff   <= step_in;
      end
      entry_ff  <= entry_in;
      symbol_ff <= digit_symbol(digit, place_ff, step_ff);
      last_ff   <= item_end;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_symbol = symbol_ff;
   assign rsp_last   = last_ff && strobe_ff;

   a_symbol_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_symbol == SYM_I || rsp_symbol == SYM_V || rsp_symbol == SYM_X ||
                      rsp_symbol == SYM_L || rsp_symbol == SYM_C || rsp_symbol == SYM_D ||
                      rsp_symbol == SYM_M))
      else $error("illegal numeral character");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (item_end && !head.valid) |=> !active_ff)
      else $error("engine still active after final character");

endmodule

// ===== rtl/core/binary_to_roman_numeral_top.sv =====
// An accepted item passes through the front end's digit conversion and the queue to the emitter,
// which skips leading zero digits; then one character per cycle, with a gap per inner zero digit.
// The front end stays busy while it converts and pushes an item, and waits while the queue is full;
// the emitter's longest numeral is that of 3888, and a two-entry queue lets both run at once.
// A synchronous reset empties the queue and stops any run; no result follows until the next
// item. Results cannot be stalled: each character is shown for exactly one cycle.
module binary_to_roman_numeral_top #(
   parameter int QueueDepth = rbn_pkg::RBN_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_value,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_symbol,
   output logic        rsp_last
);
   import rbn_pkg::*;

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   head_type  head;

   rbn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   rbn_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   rbn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

endmodule

// ===== test/tb_binary_to_roman_numeral_top.sv =====
module tb_binary_to_roman_numeral_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rbn_pkg::*;

   typedef struct packed {
      symbol_type symbol;
      logic       last;
   } roman_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [11:0] req_value = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [7:0]  rsp_symbol;
   logic        rsp_last;

   roman_char_type pending_chars[$];
   int             error_count = 0;
   int             send_idle_pct = 0;

   binary_to_roman_numeral_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .rsp_strobe (rsp_strobe),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

   always #6 clock = ~clock;

   // Builds the numeral of one value and queues its characters in order.
   function automatic void predict_numeral(input logic [11:0] value);
      symbol_type     sym_q[$];
      symbol_type     one_s[3]  = '{SYM_C, SYM_X, SYM_I};
      symbol_type     five_s[3] = '{SYM_D, SYM_L, SYM_V};
      symbol_type     ten_s[3]  = '{SYM_M, SYM_C, SYM_X};
      int unsigned    v;
      int unsigned    d;
      roman_char_type c;
      v = value;
      repeat (v / 1000) sym_q.push_back(SYM_M);
      v = v % 1000;
      for (int p = 0; p < 3; p++) begin
         d = (p == 0) ? v / 100 : (p == 1) ? (v / 10) % 10 : v % 10;
         if (d == 9) begin
            sym_q.push_back(one_s[p]);
            sym_q.push_back(ten_s[p]);
         end else if (d == 4) begin
            sym_q.push_back(one_s[p]);
            sym_q.push_back(five_s[p]);
         end else begin
            if (d >= 5) begin
               sym_q.push_back(five_s[p]);
               d = d - 5;
            end
            repeat (d) sym_q.push_back(one_s[p]);
         end
      end
      foreach (sym_q[i]) begin
         c.symbol = sym_q[i];
         c.last   = (i == sym_q.size() - 1);
         pending_chars.push_back(c);
      end
   endfunction

   task automatic send_value(input logic [11:0] value);
      req_value <= value;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
      predict_numeral(value);
      if ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   always @(posedge clock) begin
      roman_char_type want;
      if (!reset && rsp_strobe) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character %c (last %0b)", $time, rsp_symbol, rsp_last);
            error_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_symbol !== want.symbol) begin
               $display("%0t: symbol mismatch, expected %c got %c (8'h%h)",
                        $time, want.symbol, rsp_symbol, rsp_symbol);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last mismatch, expected %0b got %0b",
                        $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed_values();
      logic [11:0] values[$] = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd8, 12'd9, 12'd10,
                                 12'd40, 12'd49, 12'd90, 12'd99, 12'd400, 12'd444,
                                 12'd900, 12'd999, 12'd1000, 12'd1994, 12'd3888,
                                 12'd3999, 12'd4000, 12'd4088, 12'd4095, 12'd2048,
                                 12'd0, 12'd1666};
      send_idle_pct = 25;
      foreach (values[i]) send_value(values[i]);
   endtask

   task automatic test_random_values(input int idle_pct, input int count);
      int unsigned pick;
      logic [11:0] value;
      send_idle_pct = idle_pct;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            value = '0;
         end else if (pick < 15) begin
            value = 12'($urandom_range(4095, 4000));
         end else begin
            value = 12'($urandom_range(3999, 1));
         end
         send_value(value);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_values();
      test_random_values(25, 100);
      test_random_values(88, 100);
      test_random_values(0, 100);
      start <= 1'b0;
      for (int i = 0; i < 5000 && pending_chars.size() != 0; i++) @(posedge clock);
      if (pending_chars.size() != 0) begin
         $display("%0t: %0d characters never arrived", $time, pending_chars.size());
         error_count++;
      end
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_binary_to_roman_numeral_top: done, clean");
      end else begin
         $display("tb_binary_to_roman_numeral_top: done, errors");
      end
      $finish;
   end

   initial begin
      #3600000;
      $display("%0t: timeout", $time);
      $display("tb_binary_to_roman_numeral_top: done, errors");
      $finish;
   end

endmodule
